// ===== hdl/lsoc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsoc_pkg: shared types and constants
// Command codes, payload structs, FSM state and controller/datapath links.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lsoc_pkg;
    localparam int CHAN_W  = 16;
    localparam int IDX_W   = 16;
    localparam int DEPTH   = 65536;
    localparam int CNT_W   = 17;
    localparam int PIX_W   = 4 * CHAN_W;
    localparam logic [CHAN_W-1:0] UNIT = '1;
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_BEGIN = 2'd1,
        CMD_PIXEL = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_SKIP  = 2'd0,
        MODE_BASE  = 2'd1,
        MODE_BLEND = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]        command;
        logic              visible;
        logic [CHAN_W-1:0] opacity;
        logic [IDX_W-1:0]  pixel_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]  out_index;
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SA_MUL,
        ST_SA_DIV,
        ST_RD_WAIT,
        ST_RD_DATA,
        ST_T_MUL,
        ST_T_DIV,
        ST_C_MUL,
        ST_C_DIV,
        ST_WRITE,
        ST_RESULT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture the input beat
        logic       clr_addr;  // reset sweep address
        logic       clr_step;  // write zero and advance sweep
        logic       mem_rd;    // read frame at pixel index
        logic       cap_rd;    // capture read data
        logic       mul_sa;    // product alpha*opacity
        logic       mul_t;     // product da*(UNIT-sa)
        logic       set_sa;    // scaled alpha from product
        logic       set_t;     // t and output alpha from product
        logic       div_go;    // start divider on channel numerator
        logic       chan_rst;  // channel counter to red
        logic       chan_adv;  // store quotient, next channel
        logic       wr_base;   // write base pixel
        logic       wr_blend;  // write blended pixel
        logic       emit;      // register the read result
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic       clr_last;
        logic       div_done;
        logic       sa_zero;
        logic       in_range;
        logic       chan_last;
        logic [1:0] command;
    } t_sts;
endpackage
`default_nettype wire

// ===== hdl/layer_source_over_compositor.sv =====
// ----------------------------------------------------------------------------
// layer_source_over_compositor: straight-alpha source-over layer compositor
// ----------------------------------------------------------------------------
// Busy drops when a command is done; a begin layer never raises it. A pixel
// out of range or in a skipped layer ends after the scaled-alpha product; a
// base pixel is written once its alpha is scaled; a blended pixel whose
// scaled alpha is zero ends after the frame read; any other blended pixel
// makes three passes of the shared one-bit-per-cycle divider, one per color
// channel; a read has its result strobed in the first cycle with busy low.
// Clear sweeps the 65536-entry store one pixel a cycle; after reset busy
// stays high while the store is swept. Results cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none
module layer_source_over_compositor
    import lsoc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_in              i_item,
    output logic                  o_strobe,
    output t_out                  o_result,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_data
);
    logic [CNT_W-1:0] r_count;
    t_ctl ctl;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= CNT_RESET;
        else if (i_cfg_we) r_count <= i_cfg_data;
    end

    lsoc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_cmd(i_item.command),
        .i_sts(sts), .busy(busy), .o_ctl(ctl), .o_strobe(o_strobe)
    );

    lsoc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_count(r_count),
        .i_ctl(ctl), .o_sts(sts), .o_result(o_result)
    );
endmodule
`default_nettype wire

// ===== hdl/lsoc_ram.sv =====
// ----------------------------------------------------------------------------
// lsoc_ram: generic single-port RAM
// One write and one read per cycle at a single address, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lsoc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== hdl/lsoc_div.sv =====
// ----------------------------------------------------------------------------
// lsoc_div: restoring divider, one quotient bit per cycle
// Divides a 34-bit numerator by a 16-bit divisor; quotient saturates at UNIT.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lsoc_div
    import lsoc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_go,
    input  wire logic [33:0]       i_num,
    input  wire logic [CHAN_W-1:0] i_den,
    output logic                   o_done,
    output logic      [CHAN_W-1:0] o_quot
);
    logic [33:0]       r_num, n_num;
    logic [16:0]       r_rem, n_rem;
    logic [CHAN_W-1:0] r_den;
    logic [5:0]        r_cnt;
    logic              r_busy;
    logic [17:0]       trial;

    always_comb begin
        n_rem = {r_rem[15:0], r_num[33]};
        trial = {1'b0, n_rem} - {2'b0, r_den};
        n_num = {r_num[32:0], 1'b0};
        if (!trial[17]) begin
            n_rem    = trial[16:0];
            n_num[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd34;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    // quotient bits collect in the numerator register
    assign o_quot = (r_num[33:16] != '0) ? UNIT : r_num[15:0];
endmodule
`default_nettype wire

// ===== hdl/lsoc_datapath.sv =====
// ----------------------------------------------------------------------------
// lsoc_datapath: frame store, multiplier, divider and layer state
// Executes the steps the controller orders.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lsoc_datapath
    import lsoc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_in               i_item,
    input  wire logic [CNT_W-1:0]  i_count,
    input  wire t_ctl              i_ctl,
    output t_sts                   o_sts,
    output t_out                   o_result
);
    t_in               r_item;
    logic [IDX_W-1:0]  r_caddr;
    logic [PIX_W-1:0]  r_dst;
    logic [CHAN_W-1:0] r_sa, r_t, r_oa, r_opac;
    logic [31:0]       r_prod;
    logic [1:0]        r_chan;
    logic [CHAN_W-1:0] r_q [3];
    logic              r_base_taken;
    t_mode             r_mode;
    t_out              r_res;

    logic [PIX_W-1:0]  rdata, wdata;
    logic [IDX_W-1:0]  addr;
    logic              we;
    logic              div_done;
    logic [CHAN_W-1:0] quot, src_c, dst_c, cdiv;
    logic [33:0]       c_num;
    logic [CNT_W-1:0]  active;
    logic              in_range;

    // floor(p / UNIT) for p up to UNIT squared
    function automatic logic [CHAN_W-1:0] div_unit(input logic [31:0] p);
        logic [32:0] s;
        s = {1'b0, p} + {17'b0, p[31:16]} + 33'd1;
        return s[31:16];
    endfunction

    assign active   = (i_count > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : i_count;
    assign in_range = {1'b0, r_item.pixel_index} < active;

    assign addr  = i_ctl.clr_step ? r_caddr : r_item.pixel_index;
    assign we    = i_ctl.clr_step || i_ctl.wr_base || i_ctl.wr_blend;
    always_comb begin
        unique case (1'b1)
            i_ctl.wr_base:  wdata = {r_item.red, r_item.green, r_item.blue, r_sa};
            i_ctl.wr_blend: wdata = {r_q[0], r_q[1], r_q[2], r_oa};
            default:        wdata = '0;
        endcase
    end

    lsoc_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_frame (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    always_comb begin
        unique case (r_chan)
            2'd0:    begin src_c = r_item.red;   dst_c = r_dst[63:48]; end
            2'd1:    begin src_c = r_item.green; dst_c = r_dst[47:32]; end
            default: begin src_c = r_item.blue;  dst_c = r_dst[31:16]; end
        endcase
    end
    assign c_num = 34'({16'b0, src_c} * {16'b0, r_sa}) + 34'({16'b0, dst_c} * {16'b0, r_t});
    assign cdiv  = div_unit(r_prod);

    lsoc_div u_div (
        .i_clk (i_clk),
        .i_rst_n(i_rst_n),
        .i_go  (i_ctl.div_go),
        .i_num (c_num),
        .i_den (r_oa),
        .o_done(div_done),
        .o_quot(quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_taken <= 1'b0;
            r_mode       <= MODE_SKIP;
            r_opac       <= UNIT;
            r_caddr      <= '0;
        end else begin
            if (i_ctl.clr_addr) r_caddr <= '0;
            else if (i_ctl.clr_step) r_caddr <= r_caddr + IDX_W'(1);
            if (i_ctl.load && t_cmd'(i_item.command) == CMD_CLEAR) begin
                r_base_taken <= 1'b0;
                r_mode       <= MODE_SKIP;
            end
            if (i_ctl.load && t_cmd'(i_item.command) == CMD_BEGIN) begin
                r_opac <= i_item.opacity;
                if (!i_item.visible) begin
                    r_mode <= MODE_SKIP;
                end else if (!r_base_taken) begin
                    r_mode       <= MODE_BASE;
                    r_base_taken <= 1'b1;
                end else begin
                    r_mode <= MODE_BLEND;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) r_item <= i_item;
        if (i_ctl.cap_rd) r_dst <= rdata;
        if (i_ctl.mul_sa) r_prod <= {16'b0, r_item.alpha} * {16'b0, r_opac};
        if (i_ctl.mul_t) r_prod <= {16'b0, r_dst[15:0]} * {16'b0, UNIT - r_sa};
        if (i_ctl.set_sa) r_sa <= cdiv;
        if (i_ctl.set_t) begin
            r_t  <= cdiv;
            r_oa <= r_sa + cdiv;
        end
        if (i_ctl.chan_rst) r_chan <= 2'd0;
        else if (i_ctl.chan_adv) begin
            r_q[r_chan] <= quot;
            r_chan      <= r_chan + 2'd1;
        end
        if (i_ctl.emit) begin
            r_res.out_index <= r_item.pixel_index;
            r_res.out_red   <= in_range ? rdata[63:48] : '0;
            r_res.out_green <= in_range ? rdata[47:32] : '0;
            r_res.out_blue  <= in_range ? rdata[31:16] : '0;
            r_res.out_alpha <= in_range ? rdata[15:0]  : '0;
        end
    end

    assign o_result = r_res;
    assign o_sts.clr_last  = (r_caddr == IDX_W'(DEPTH - 1));
    assign o_sts.div_done  = div_done;
    assign o_sts.sa_zero   = (r_sa == '0);
    assign o_sts.in_range  = in_range && (r_mode != MODE_SKIP || r_item.command == CMD_READ);
    assign o_sts.chan_last = (r_chan == 2'd2);
    assign o_sts.command   = (r_mode == MODE_BASE && r_item.command == CMD_PIXEL)
                             ? 2'd1 : r_item.command;
endmodule
`default_nettype wire

// ===== hdl/lsoc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsoc_ctrl: command sequencer
// Walks clear sweeps, pixel blends and reads through the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lsoc_ctrl
    import lsoc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire logic [1:0] i_cmd,
    input  wire t_sts i_sts,
    output logic      busy,
    output t_ctl      o_ctl,
    output logic      o_strobe
);
    t_state r_state, n_state;
    logic   r_strobe;
    logic   accept;
    logic   is_base;

    assign accept  = start && !busy;
    assign is_base = (i_sts.command == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_RESULT);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_CLEAR: n_state = ST_CLEAR;
                        CMD_BEGIN: n_state = ST_IDLE;
                        CMD_PIXEL: n_state = ST_SA_MUL;
                        default:   n_state = ST_RD_WAIT;
                    endcase
                end
            end
            ST_CLEAR:   if (i_sts.clr_last) n_state = ST_IDLE;
            ST_SA_MUL:  n_state = i_sts.in_range ? ST_SA_DIV : ST_IDLE;
            ST_SA_DIV:  n_state = is_base ? ST_WRITE : ST_RD_WAIT;
            ST_RD_WAIT: n_state = ST_RD_DATA;
            ST_RD_DATA: begin
                if (i_sts.command == CMD_READ) n_state = ST_RESULT;
                else if (i_sts.sa_zero) n_state = ST_IDLE;
                else n_state = ST_T_MUL;
            end
            ST_T_MUL:   n_state = ST_T_DIV;
            ST_T_DIV:   n_state = ST_C_MUL;
            ST_C_MUL:   n_state = ST_C_DIV;
            ST_C_DIV:   if (i_sts.div_done) n_state = i_sts.chan_last ? ST_WRITE : ST_C_MUL;
            ST_WRITE:   n_state = ST_IDLE;
            ST_RESULT:  n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        busy  = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_ctl.load     = accept;
                o_ctl.clr_addr = 1'b1;
                o_ctl.chan_rst = 1'b1;
            end
            ST_CLEAR:   o_ctl.clr_step = 1'b1;
            ST_SA_MUL:  begin o_ctl.mul_sa = 1'b1; end
            ST_SA_DIV:  begin
                o_ctl.set_sa = 1'b1;
            end
            ST_RD_WAIT: o_ctl.mem_rd = 1'b1;
            ST_RD_DATA: o_ctl.cap_rd = 1'b1;
            ST_T_MUL:   o_ctl.mul_t = 1'b1;
            ST_T_DIV:   o_ctl.set_t = 1'b1;
            // launch the divider as the channel numerator is formed
            ST_C_MUL:   o_ctl.div_go = 1'b1;
            ST_C_DIV:   begin
                o_ctl.chan_adv = i_sts.div_done;
            end
            ST_WRITE:   begin
                o_ctl.wr_base  = is_base;
                o_ctl.wr_blend = !is_base;
            end
            ST_RESULT:  o_ctl.emit = 1'b1;
            default:    o_ctl = '0;
        endcase
    end

    assign o_strobe = r_strobe;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_ctl.load) else $error("load while busy");
    a_strobe_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == ST_RESULT) else $error("stray strobe");
    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.wr_base && o_ctl.wr_blend)) else $error("double write");
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for layer_source_over_compositor
// Streams clears, layers, layer pixels and reads with random gaps, predicts
// each composite pixel in a scoreboard and compares every read beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import lsoc_pkg::*;

    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 300000;

    class composite_scoreboard;
        logic [PIX_W-1:0] frame[int];
        bit               base_taken;
        t_mode            mode;
        logic [15:0]      opacity;
        int unsigned      pixel_count;
        t_out             pending[$];
        int               errors;

        function new();
            base_taken  = 0;
            mode        = MODE_SKIP;
            opacity     = UNIT;
            pixel_count = 65536;
            errors      = 0;
        endfunction

        function longint unsigned scale(longint unsigned x, longint unsigned y);
            return (x * y) / 65535;
        endfunction

        function bit in_range(int unsigned idx);
            int unsigned n;
            n = (pixel_count > 65536) ? 65536 : pixel_count;
            return idx < n;
        endfunction

        function void blend_pixel(t_in it);
            logic [PIX_W-1:0] px;
            longint unsigned  sa, t, oa, q;
            longint unsigned  src[3], dst[3];
            px = frame.exists(it.pixel_index) ? frame[it.pixel_index] : '0;
            sa = scale(it.alpha, opacity);
            if (mode == MODE_BASE) begin
                frame[it.pixel_index] = {it.red, it.green, it.blue, 16'(sa)};
                return;
            end
            if (sa == 0) return;
            src = '{it.red, it.green, it.blue};
            dst = '{px[63:48], px[47:32], px[31:16]};
            t  = scale(px[15:0], 65535 - sa);
            oa = sa + t;
            for (int c = 0; c < 3; c++) begin
                q = (src[c] * sa + dst[c] * t) / oa;
                if (q > 65535) q = 65535;
                dst[c] = q;
            end
            frame[it.pixel_index] = {16'(dst[0]), 16'(dst[1]), 16'(dst[2]), 16'(oa)};
        endfunction

        function void note_item(t_in it);
            t_out r;
            case (t_cmd'(it.command))
                CMD_CLEAR: begin
                    frame.delete();
                    base_taken = 0;
                    mode = MODE_SKIP;
                end
                CMD_BEGIN: begin
                    opacity = it.opacity;
                    if (!it.visible) mode = MODE_SKIP;
                    else if (!base_taken) begin
                        mode = MODE_BASE;
                        base_taken = 1;
                    end else mode = MODE_BLEND;
                end
                CMD_PIXEL: begin
                    if (mode != MODE_SKIP && in_range(it.pixel_index)) blend_pixel(it);
                end
                CMD_READ: begin
                    r = '0;
                    r.out_index = it.pixel_index;
                    if (in_range(it.pixel_index) && frame.exists(it.pixel_index))
                        {r.out_red, r.out_green, r.out_blue, r.out_alpha} =
                            frame[it.pixel_index];
                    pending = {pending, r};
                end
            endcase
        endfunction

        function void check_result(t_out got);
            t_out exp_px;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_px = pending.pop_front();
            if (got.out_index !== exp_px.out_index)
                report("out_index", exp_px.out_index, got.out_index);
            if (got.out_red !== exp_px.out_red)
                report("out_red", exp_px.out_red, got.out_red);
            if (got.out_green !== exp_px.out_green)
                report("out_green", exp_px.out_green, got.out_green);
            if (got.out_blue !== exp_px.out_blue)
                report("out_blue", exp_px.out_blue, got.out_blue);
            if (got.out_alpha !== exp_px.out_alpha)
                report("out_alpha", exp_px.out_alpha, got.out_alpha);
        endfunction

        function void report(string field, logic [15:0] e, logic [15:0] a);
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, e, a);
            errors++;
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_in              i_item;
    logic             o_strobe;
    t_out             o_result;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;

    composite_scoreboard sb;
    int                  stall_cycles;
    bit                  steady;

    layer_source_over_compositor i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_item(i_item);
            if (o_strobe) sb.check_result(o_result);
            if ((start && !busy) || o_strobe) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[layer_source_over_compositor] ERROR");
                $finish;
            end
        end
    end

    function int gap_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function logic [15:0] chan();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function t_in make_item(t_cmd cmd, logic [15:0] idx);
        t_in it;
        it.command     = cmd;
        it.visible     = 1'($urandom_range(0, 1));
        it.opacity     = chan();
        it.pixel_index = idx;
        it.red         = chan();
        it.green       = chan();
        it.blue        = chan();
        it.alpha       = chan();
        return it;
    endfunction

    function t_in make_layer(bit vis, logic [15:0] opac);
        t_in it;
        it = make_item(CMD_BEGIN, 16'($urandom));
        it.visible = vis;
        it.opacity = opac;
        return it;
    endfunction

    // hold the beat until busy is seen low ahead of a rising edge
    task automatic send(t_in it);
        int g;
        g = gap_len();
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // write the pixel count only with the block drained and idle
    task automatic write_count(logic [CNT_W-1:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.pixel_count = value;
    endtask

    task automatic run_phase(logic [CNT_W-1:0] count, int n_items);
        int unsigned span;
        int          sent;
        int          r;
        t_in         it;
        write_count(count);
        send(make_item(CMD_CLEAR, 16'($urandom)));
        span = (count > 40) ? 40 : count + 2;
        sent = 0;
        steady = $urandom_range(0, 3) == 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send(make_layer($urandom_range(0, 9) != 0, chan()));
            end else if (r < 62) begin
                send(make_item(CMD_PIXEL, 16'($urandom_range(0, span))));
            end else if (r < 92) begin
                send(make_item(CMD_READ, 16'($urandom_range(0, span))));
            end else begin
                // noise: any position, any non-clear command
                it = make_item(t_cmd'($urandom_range(1, 3)), 16'($urandom));
                send(it);
            end
            sent++;
            if ($urandom_range(0, 49) == 0) steady = ~steady;
        end
    endtask

    initial begin
        t_in it;
        sb           = new();
        stall_cycles = 0;
        steady       = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: layer edge cases at full frame
        write_count(CNT_W'(65536));
        send(make_item(CMD_PIXEL, 16'd0));
        send(make_item(CMD_READ, 16'd0));
        send(make_layer(1'b0, 16'hFFFF));
        send(make_item(CMD_PIXEL, 16'd1));
        send(make_item(CMD_READ, 16'd1));
        send(make_layer(1'b1, 16'hFFFF));
        it = make_item(CMD_PIXEL, 16'd0);
        {it.red, it.green, it.blue, it.alpha} = '0;
        send(it);
        it = make_item(CMD_PIXEL, 16'hFFFF);
        {it.red, it.green, it.blue, it.alpha} = '1;
        send(it);
        send(make_item(CMD_PIXEL, 16'd2));
        send(make_item(CMD_READ, 16'hFFFF));
        send(make_layer(1'b1, 16'h0000));
        send(make_item(CMD_PIXEL, 16'd2));
        send(make_layer(1'b1, 16'h8000));
        it = make_item(CMD_PIXEL, 16'd2);
        it.alpha = 16'hFFFF;
        send(it);
        it = make_item(CMD_PIXEL, 16'd0);
        it.alpha = 16'h0000;
        send(it);
        it = make_item(CMD_PIXEL, 16'hFFFF);
        it.alpha = 16'h0001;
        send(it);
        send(make_item(CMD_READ, 16'd0));
        send(make_item(CMD_READ, 16'd2));
        send(make_item(CMD_READ, 16'hFFFF));
        // out of range at the smallest frame, then an in-range read
        write_count(CNT_W'(1));
        send(make_item(CMD_PIXEL, 16'd1));
        send(make_item(CMD_READ, 16'd2));
        send(make_item(CMD_READ, 16'd0));

        run_phase(CNT_W'(1), 150);
        run_phase(CNT_W'(131071), 350);
        run_phase(CNT_W'(65536), 350);
        run_phase(CNT_W'($urandom_range(2, 40)), 350);
        run_phase(CNT_W'($urandom_range(41, 65535)), 330);

        start <= 1'b0;
        @(posedge i_clk);
        while (busy || sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[layer_source_over_compositor] OK");
        else
            $display("[layer_source_over_compositor] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
